>>> sv/ssi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Simpson sample integrator.
// No dependencies; imported by every module of the block.
package ssi_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W  = 32;
    localparam int RANGE_W   = 32;
    localparam int RESULT_W  = 64;
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W    = RANGE_W + 1;
    localparam int ENDS_W    = SAMPLE_W + 4;

    // Long multiply / divide: 64-bit magnitude times 33-bit magnitude
    localparam int MAG_W     = 64;
    localparam int WORK_W    = MAG_W + DIFF_W;
    localparam int MUL_STEPS = DIFF_W;
    localparam int DIV_STEPS = WORK_W;
    localparam int STEP_W    = 7;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'b1;

    localparam logic signed [RANGE_W-1:0] RANGE_END_RESET = 32'sh0001_0000;

    localparam logic [RESULT_W-1:0] RESULT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [RESULT_W-1:0] RESULT_MIN = 64'h8000_0000_0000_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic take;
        logic calc_ends;
        logic calc_sum;
        logic load_abs;
        logic mul_step;
        logic add_half;
        logic div_step;
        logic load_out;
    } ssi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic few;
    } ssi_status_t;

endpackage

>>> sv/ssi_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and integrals out.
// Depends on ssi_pkg for field widths.
interface ssi_sample_if
    import ssi_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface ssi_result_if
    import ssi_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] integral;
    logic                       too_few_samples;
    logic                       saturated;

    modport source (output valid, output integral, output too_few_samples,
                    output saturated, input ready);
    modport sink   (input valid, input integral, input too_few_samples,
                    input saturated, output ready);
endinterface

>>> sv/ssi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the integrator: sample intake, end-of-run finish, result hand-off.
// Depends on ssi_pkg for the command and status structs.
module ssi_ctrl
    import ssi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ssi_status_t status,
    output ssi_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENDS = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_HALF = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              take;
    logic              load_out;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && in_ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Command decode
    always_comb
    begin
        cmd           = '0;
        cmd.take      = take;
        cmd.calc_ends = (state_reg == ST_ENDS);
        cmd.calc_sum  = (state_reg == ST_SUM);
        cmd.load_abs  = (state_reg == ST_ABS);
        cmd.mul_step  = (state_reg == ST_MUL);
        cmd.add_half  = (state_reg == ST_HALF);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.load_out  = load_out;
    end

    // Next state and step counter
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && in_last)
                begin
                    state_next = ST_ENDS;
                end
            end
            ST_ENDS: state_next = ST_SUM;
            ST_SUM:  state_next = status.few ? ST_DONE : ST_ABS;
            ST_ABS:
            begin
                state_next = ST_MUL;
                step_next  = '0;
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_HALF;
                end
            end
            ST_HALF:
            begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output beat holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/ssi_datapath.sv
`timescale 1ns / 1ps
// Datapath: run state, window accumulator, shift-add multiplier, restoring divider.
// Depends on ssi_pkg; driven by ssi_ctrl commands.
module ssi_datapath
    import ssi_pkg::*;
#(
    parameter int MAX_SAMPLES   = 4096,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssi_cmd_t                    cmd,
    output ssi_status_t                 status,
    input  logic signed [SAMPLE_W-1:0]  sample_value,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [RANGE_W-1:0]          cfg_data,
    output logic signed [RESULT_W-1:0]  integral,
    output logic                        too_few_samples,
    output logic                        saturated
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [RESULT_W-1:0] FEW_RESULT = ~(RESULT_W'(1) << (FRACTION_BITS - 1)) + 1'b1;

    // Run state
    logic [CNT_W-1:0]           count_reg;
    logic signed [SAMPLE_W-1:0] first_reg  [3];
    logic signed [SAMPLE_W-1:0] recent_reg [3];
    logic signed [RESULT_W-1:0] wsum_reg;
    logic signed [RANGE_W-1:0]  start_reg, end_reg;

    // Finish pipeline
    logic signed [ENDS_W-1:0]   ends_a_reg, ends_b_reg;
    logic [MAG_W-1:0]           div_reg;
    logic                       few_reg;
    logic signed [RESULT_W-1:0] s_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    logic [MAG_W-1:0]           ms_reg;
    logic                       neg_reg;
    logic [WORK_W-1:0]          work_reg;
    logic [MAG_W-1:0]           rem_reg;
    logic [RESULT_W-1:0]        integral_reg;
    logic                       few_out_reg, sat_out_reg;

    logic signed [RESULT_W-1:0] window;
    logic signed [ENDS_W-1:0]   f0, f1, f2, r0, r1, r2;
    logic [DIFF_W-1:0]          md;
    logic [MAG_W:0]             mul_sum;
    logic [MAG_W:0]             div_pre;
    logic                       div_ge;
    logic [MAG_W:0]             div_diff;
    logic                       over;
    logic [RESULT_W-1:0]        result;

    assign status.few      = few_reg;
    assign integral        = integral_reg;
    assign too_few_samples = few_out_reg;
    assign saturated       = sat_out_reg;

    // Window term y[i] + 4*y[i+1] + y[i+2]
    assign window = RESULT_W'(recent_reg[1]) + (RESULT_W'(recent_reg[2]) <<< 2)
                    + RESULT_W'(sample_value);

    // End-correction operands
    assign f0 = ENDS_W'(first_reg[0]);
    assign f1 = ENDS_W'(first_reg[1]);
    assign f2 = ENDS_W'(first_reg[2]);
    assign r0 = ENDS_W'(recent_reg[0]);
    assign r1 = ENDS_W'(recent_reg[1]);
    assign r2 = ENDS_W'(recent_reg[2]);

    assign md = d_reg[DIFF_W-1] ? (~d_reg + 1'b1) : d_reg;

    // One shift-add step: add multiplicand when the low multiplier bit is set
    assign mul_sum = {1'b0, work_reg[WORK_W-1:DIFF_W]}
                     + (work_reg[0] ? {1'b0, ms_reg} : {(MAG_W + 1){1'b0}});

    // One restoring division step
    assign div_pre  = {rem_reg, work_reg[WORK_W-1]};
    assign div_ge   = div_pre >= {1'b0, div_reg};
    assign div_diff = div_pre - {1'b0, div_reg};

    // Saturate the quotient magnitude and apply the sign
    always_comb
    begin
        if (neg_reg)
        begin
            over   = (|work_reg[WORK_W-1:MAG_W]) || (work_reg[MAG_W-1:0] > RESULT_MIN);
            result = over ? RESULT_MIN : (~work_reg[MAG_W-1:0] + 1'b1);
        end
        else
        begin
            over   = |work_reg[WORK_W-1:MAG_W-1];
            result = over ? RESULT_MAX : work_reg[MAG_W-1:0];
        end
    end

    // Config registers and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= RANGE_END_RESET;
            count_reg <= '0;
            wsum_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i]  <= '0;
                recent_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_RANGE_START)
                begin
                    start_reg <= cfg_data;
                end
                else if (cfg_index == REG_RANGE_END)
                begin
                    end_reg <= cfg_data;
                end
            end
            if (cmd.take && (count_reg < CNT_MAX))
            begin
                if (count_reg < CNT_THREE)
                begin
                    first_reg[count_reg[1:0]] <= sample_value;
                end
                recent_reg[0] <= recent_reg[1];
                recent_reg[1] <= recent_reg[2];
                recent_reg[2] <= sample_value;
                count_reg     <= count_reg + 1'b1;
                if (count_reg >= CNT_TWO)
                begin
                    wsum_reg <= wsum_reg + window;
                end
            end
            else if (cmd.calc_sum)
            begin
                count_reg <= '0;
                wsum_reg  <= '0;
            end
        end
    end

    // Finish pipeline: end terms, sum, magnitudes, multiply, round, divide, output
    always_ff @(posedge clk)
    begin
        if (cmd.calc_ends)
        begin
            ends_a_reg <= (f0 <<< 2) + f0 + (f1 <<< 3) - f2;
            ends_b_reg <= (r2 <<< 2) + r2 + (r1 <<< 3) - r0;
            div_reg    <= ((MAG_W'(count_reg) << 4) + (MAG_W'(count_reg) << 3))
                          << FRACTION_BITS;
            few_reg    <= count_reg < CNT_THREE;
        end
        if (cmd.calc_sum)
        begin
            s_reg <= RESULT_W'(ends_a_reg) + RESULT_W'(ends_b_reg) + (wsum_reg <<< 2);
            d_reg <= DIFF_W'(end_reg) - DIFF_W'(start_reg);
        end
        if (cmd.load_abs)
        begin
            neg_reg  <= s_reg[RESULT_W-1] ^ d_reg[DIFF_W-1];
            ms_reg   <= s_reg[RESULT_W-1] ? (~s_reg + 1'b1) : s_reg;
            work_reg <= {{MAG_W{1'b0}}, md};
        end
        else if (cmd.mul_step)
        begin
            work_reg <= {mul_sum, work_reg[DIFF_W-1:1]};
        end
        else if (cmd.add_half)
        begin
            work_reg <= work_reg + WORK_W'(div_reg >> 1);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= {work_reg[WORK_W-2:0], div_ge};
            rem_reg  <= div_ge ? div_diff[MAG_W-1:0] : div_pre[MAG_W-1:0];
        end
        if (cmd.load_out)
        begin
            if (few_reg)
            begin
                integral_reg <= FEW_RESULT;
                few_out_reg  <= 1'b1;
                sat_out_reg  <= 1'b0;
            end
            else
            begin
                integral_reg <= result;
                few_out_reg  <= 1'b0;
                sat_out_reg  <= over;
            end
        end
    end

endmodule

>>> sv/simpson_sample_integrator.sv
`timescale 1ns / 1ps
// A sample without the last flag is taken while idle; the next can follow at once.
// A flagged last sample starts the finish: end terms, sum, then for three or more samples
// magnitudes, a 33-step multiply, rounding and a 97-step divide before the result beat.
// No sample is taken during the finish; the result waits in an output register.
// Reset (rst_n low, async) clears the run, sets range 0..1.0 and drops the result beat.
module simpson_sample_integrator
    import ssi_pkg::*;
#(
    parameter int MAX_SAMPLES   = 4096,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ssi_sample_if.sink           samples,
    ssi_result_if.source         results,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data
);

    ssi_cmd_t    cmd;
    ssi_status_t status;

    // Sequencer
    ssi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last_sample),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and run state
    ssi_datapath #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample_value    (samples.sample_value),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .integral        (results.integral),
        .too_few_samples (results.too_few_samples),
        .saturated       (results.saturated)
    );

endmodule

>>> sv/ssi_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the integrator, bound to the top level.
// Depends on ssi_pkg for widths and saturation limits.
module ssi_checker
    import ssi_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [RESULT_W-1:0] integral,
    input logic                       too_few_samples,
    input logic                       saturated
);

    localparam logic [RESULT_W-1:0] FEW_RESULT = ~(RESULT_W'(1) << (FRACTION_BITS - 1)) + 1'b1;

    // A plain sample never stalls the intake
    a_plain_beat_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last |=> in_ready)
        else $error("intake stalled after a plain sample");

    // The last sample starts the finish, which blocks intake
    a_last_beat_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("intake open right after a last sample");

    // Short run gives the fixed fallback value
    a_few_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_few_samples |-> integral == FEW_RESULT && !saturated)
        else $error("short-run result is not the fallback value");

    // Clipped result sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> integral == RESULT_MAX || integral == RESULT_MIN)
        else $error("saturated result is not at a limit");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(integral))
        else $error("result beat changed while stalled");

endmodule

bind simpson_sample_integrator ssi_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_ssi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .in_last         (samples.last_sample),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .integral        (results.integral),
    .too_few_samples (results.too_few_samples),
    .saturated       (results.saturated)
);

>>> verif/simpson_sample_integrator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for simpson_sample_integrator: directed and random runs of
// samples with random gaps and stalls, checked by an in-bench Simpson-rule predictor.
// Depends on ssi_pkg, ssi_if.sv and the block itself.
module simpson_sample_integrator_test
    import ssi_pkg::*;
();

    localparam int MAX_RUN = 4096;
    localparam int FRAC    = 16;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } sample_beat_t;

    typedef struct {
        logic [RESULT_W-1:0] integral;
        logic                too_few;
        logic                saturated;
    } integral_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [RANGE_W-1:0]         cfg_data     = '0;

    // Bench-side copies of the channel signals, known from time zero
    logic                       smp_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] smp_value = '0;
    logic                       smp_last  = 1'b0;
    logic                       res_ready = 1'b0;

    ssi_sample_if samples();
    ssi_result_if results();

    assign samples.valid        = smp_valid;
    assign samples.sample_value = smp_value;
    assign samples.last_sample  = smp_last;
    assign results.ready        = res_ready;

    simpson_sample_integrator #(
        .MAX_SAMPLES   (MAX_RUN),
        .FRACTION_BITS (FRAC)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .results      (results),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Stimulus and expectation stores
    sample_beat_t   sample_backlog[$];
    integral_beat_t pending_integrals[$];
    sample_beat_t   next_beat;
    integral_beat_t got_beat;
    integral_beat_t want_beat;

    int  mismatch_count = 0;
    int  send_gap       = 0;
    int  take_gap       = 0;
    logic calm          = 1'b0;

    // Predictor state: interval and the run in progress
    logic signed [RANGE_W-1:0] range_lo = '0;
    logic signed [RANGE_W-1:0] range_hi = RANGE_END_RESET;
    int     run_length = 0;
    longint head[3]    = '{0, 0, 0};
    longint tail[3]    = '{0, 0, 0};
    longint window_sum = 0;

    // Final scale of a run: S * D / (24 * n * 2^FRAC), rounded half away from zero
    function automatic integral_beat_t settle_integral();
        integral_beat_t r;
        longint         s;
        longint         d;
        logic [127:0]   ms;
        logic [127:0]   md;
        logic [127:0]   den;
        logic [127:0]   quo;
        bit             neg;
        r.too_few   = 1'b0;
        r.saturated = 1'b0;
        if (run_length < 3)
        begin
            r.integral = 64'd0 - (64'd1 << (FRAC - 1));
            r.too_few  = 1'b1;
            return r;
        end
        s = 5 * head[0] + 8 * head[1] - head[2]
            - tail[0] + 8 * tail[1] + 5 * tail[2] + 4 * window_sum;
        d = longint'(range_hi) - longint'(range_lo);
        neg = (s < 0) != (d < 0);
        ms  = 128'(s < 0 ? -s : s);
        md  = 128'(d < 0 ? -d : d);
        den = 128'(24 * run_length) << FRAC;
        quo = (ms * md + (den >> 1)) / den;
        if (neg)
        begin
            if (quo > (128'd1 << 63))
            begin
                quo         = 128'd1 << 63;
                r.saturated = 1'b1;
            end
            r.integral = 64'd0 - quo[63:0];
        end
        else
        begin
            if (quo > 128'(RESULT_MAX))
            begin
                quo         = 128'(RESULT_MAX);
                r.saturated = 1'b1;
            end
            r.integral = quo[63:0];
        end
        return r;
    endfunction

    // Fold one accepted sample into the run; a flagged one closes it
    function automatic void take_sample(input logic signed [SAMPLE_W-1:0] y, input logic last);
        integral_beat_t fin;
        if (run_length < MAX_RUN)
        begin
            if (run_length < 3)
                head[run_length] = longint'(y);
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = longint'(y);
            run_length++;
            if (run_length >= 3)
                window_sum += tail[0] + 4 * tail[1] + tail[2];
        end
        if (last)
        begin
            fin = settle_integral();
            pending_integrals = {pending_integrals, fin};
            run_length = 0;
            window_sum = 0;
            head       = '{0, 0, 0};
            tail       = '{0, 0, 0};
        end
    endfunction

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sample driver: random idle bursts between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid <= 1'b0;
            smp_value <= '0;
            smp_last  <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            if (smp_valid && samples.ready)
                take_sample(smp_value, smp_last);
            if (!smp_valid || samples.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    smp_valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0 && !calm && $urandom_range(0, 19) == 0)
                begin
                    send_gap  <= $urandom_range(1, 16) - 1;
                    smp_valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0)
                begin
                    next_beat = sample_backlog.pop_front();
                    smp_value <= next_beat.value;
                    smp_last  <= next_beat.last;
                    smp_valid <= 1'b1;
                end
                else
                    smp_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each beat and stalls ready in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            take_gap  <= 0;
        end
        else
        begin
            if (results.valid && res_ready)
            begin
                got_beat.integral  = results.integral;
                got_beat.too_few   = results.too_few_samples;
                got_beat.saturated = results.saturated;
                if (pending_integrals.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat: integral %h too_few %b sat %b",
                                 got_beat.integral, got_beat.too_few,
                                 got_beat.saturated);
                    mismatch_count++;
                end
                else
                begin
                    want_beat = pending_integrals.pop_front();
                    if (got_beat.integral !== want_beat.integral
                        || got_beat.too_few !== want_beat.too_few
                        || got_beat.saturated !== want_beat.saturated)
                    begin
                        if (mismatch_count < 10)
                            $display({"mismatch: integral exp %h got %h, ",
                                      "too_few exp %b got %b, saturated exp %b got %b"},
                                     want_beat.integral, got_beat.integral,
                                     want_beat.too_few, got_beat.too_few,
                                     want_beat.saturated, got_beat.saturated);
                        mismatch_count++;
                    end
                end
            end
            if (take_gap != 0)
            begin
                take_gap  <= take_gap - 1;
                res_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                take_gap  <= $urandom_range(1, 16) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    function automatic void add_beat(input logic signed [SAMPLE_W-1:0] v, input logic last);
        sample_beat_t b;
        b.value = v;
        b.last  = last;
        sample_backlog = {sample_backlog, b};
    endfunction

    // Mostly full-range values, with extremes and small values mixed in
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 2097152)) - 1048576);
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_run(input int len);
        for (int i = 0; i < len; i++)
            add_beat(pick_sample(), i == len - 1);
    endfunction

    function automatic int pick_run_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return $urandom_range(1, 2);
        if (r == 2)
            return $urandom_range(25, 60);
        return $urandom_range(3, 24);
    endfunction

    // Both range registers on back-to-back edges, block idle
    task automatic write_range(input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_RANGE_START;
        cfg_data     <= lo;
        @(posedge clk);
        cfg_index    <= REG_RANGE_END;
        cfg_data     <= hi;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        range_lo = lo;
        range_hi = hi;
    endtask

    // Wait until every queued beat is taken and every integral has come back
    task automatic drain_run();
        while (sample_backlog.size() != 0 || smp_valid || pending_integrals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        int filled;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed runs on the reset interval: too short, extremes, sign flips
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MAX, 1'b0);
        add_beat(SAMPLE_MAX, 1'b1);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b0);
        add_beat(SAMPLE_MIN, 1'b1);
        add_beat(32'sd0, 1'b0);
        add_beat(-32'sd1, 1'b0);
        add_beat(32'sd1, 1'b0);
        add_beat(32'sh0001_0000, 1'b1);
        for (int i = 0; i < 5; i++)
            add_beat((i % 2) ? SAMPLE_MIN : SAMPLE_MAX, i == 4);
        drain_run();

        // Random runs over several interval settings
        for (int p = 0; p < 8; p++)
        begin
            unique case (p)
                0: write_range(SAMPLE_MIN, SAMPLE_MAX);
                1: write_range(SAMPLE_MAX, SAMPLE_MIN);
                2: write_range(32'd0, 32'd0);
                3: write_range(32'hFFFF_0000, 32'h0001_0000);
                default: write_range($urandom(), $urandom());
            endcase
            if (p == 7)
                calm <= 1'b1;
            filled = 0;
            while (filled < 105)
            begin
                int len;
                len = pick_run_length();
                push_run(len);
                filled += len;
            end
            drain_run();
        end

        drain_run();
        repeat (150) @(posedge clk);
        if (mismatch_count == 0 && pending_integrals.size() == 0)
            $display("PASS simpson_sample_integrator");
        else
            $display("FAIL simpson_sample_integrator");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("FAIL simpson_sample_integrator");
        $finish;
    end

endmodule

>>> simpson_sample_integrator.f
sv/ssi_pkg.sv
sv/ssi_if.sv
sv/ssi_ctrl.sv
sv/ssi_datapath.sv
sv/simpson_sample_integrator.sv
sv/ssi_checker.sv
verif/simpson_sample_integrator_test.sv
